FILE: design/lsm_pkg.sv
// Shared types and constants of the memtable write buffer.
`timescale 1ns / 1ps
package lsm_pkg;
  localparam int BlockSize = 32;
  localparam int IdxW = $clog2(BlockSize);
  localparam int CntW = $clog2(BlockSize + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ANSWER = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SHIFT, ST_SORT_CMP, ST_EMIT_RD,
    ST_EMIT, ST_STORE, ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_req;
    logic       hit_latch;   // capture hit and its value at scan index
    logic       scan_step;
    logic       shift_step;
    logic       del_done;
    logic       upd_write;
    logic       store_pair;
    logic       sort_init;
    logic       sort_cmp;
    logic       emit_rd;
    logic       emit_step;
    logic       resp_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic scan_end;
    logic hit;
    logic shift_end;
    logic sort_end;
    logic emit_end;
  } status_t;
endpackage

FILE: design/lsm_memtable_buffer.sv
// Top level of the memtable write buffer.
`timescale 1ns / 1ps
// Memtable write buffer of an LSM tree: holds up to 32 key/value pairs in
// arrival order. Requests are insert, lookup, delete and update. An insert
// (or update miss) on a full buffer flushes all 32 entries as a run, sorted
// stably by key when sort_on_flush is set, then stores the new pair. One
// request at a time: a lookup/delete/update scans the store one entry per
// cycle, a delete shifts later entries one per cycle, a sorted flush runs
// a selection pass over all 32 entries before it reads and emits each
// entry, an unsorted flush reads and emits the entries in store order, and
// emission waits while out_ready is low. A plain insert passes the scan,
// store and response states, a scanning request its scan and the response
// state (plus the shift for a delete hit). in_ready is low while a request
// is being worked on. No clearing pass after reset.
module lsm_memtable_buffer import lsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        found,
  output logic [63:0] out_key,
  output logic [63:0] out_value,
  output logic        last,
  output logic [5:0]  fill_level
);
  logic    sort_on_flush;
  logic    busy, in_fire, out_free;
  cmd_t    cmd;
  status_t sts;
  mode_t   mode_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) sort_on_flush <= 1'b1;
    else if (cfg_valid && cfg_ready) sort_on_flush <= cfg_data;
  end

  lsm_ctrl u_ctrl (
    .clk, .rst, .in_fire, .mode_q, .sort_on_flush, .out_free,
    .sts, .busy, .cmd
  );

  lsm_dp u_dp (
    .clk, .rst, .cmd, .mode_in(mode_t'(mode)), .key_in(key), .value_in(value),
    .out_ready, .mode_q, .sts, .out_valid, .out_free, .kind, .found,
    .out_key, .out_value, .last, .fill_level
  );

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready) else $error("accepted while busy");
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= 6'(BlockSize)) else $error("fill overflow");
  a_run_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RUN) |-> !found) else $error("run with found");
endmodule

FILE: design/lsm_ctrl.sv
// Sequencer for scan, shift, sort and flush of the memtable.
`timescale 1ns / 1ps
module lsm_ctrl import lsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  mode_t   mode_q,
  input  logic    sort_on_flush,
  input  logic    out_free,
  input  status_t sts,
  output logic    busy,
  output cmd_t    cmd
);
  state_t state, state_next;
  logic   need_flush;

  assign need_flush = sts.full;
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire) state_next = ST_SCAN;
      ST_SCAN: begin
        if (mode_q == MODE_INSERT) begin
          if (need_flush) state_next = sort_on_flush ? ST_SORT_CMP : ST_EMIT_RD;
          else            state_next = ST_STORE;
        end else if (sts.hit || sts.scan_end) begin
          priority case (1'b1)
            mode_q == MODE_LOOKUP:             state_next = ST_RESP;
            mode_q == MODE_DELETE && sts.hit:  state_next = ST_SHIFT;
            mode_q == MODE_DELETE:             state_next = ST_RESP;
            sts.hit:                           state_next = ST_RESP;
            need_flush: state_next = sort_on_flush ? ST_SORT_CMP : ST_EMIT_RD;
            default:                           state_next = ST_STORE;
          endcase
        end
      end
      ST_SHIFT:    if (sts.shift_end) state_next = ST_RESP;
      ST_SORT_CMP: state_next = sts.sort_end ? ST_EMIT_RD : ST_SORT_CMP;
      ST_EMIT_RD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (sts.emit_end)   state_next = ST_STORE;
          else                state_next = sort_on_flush ? ST_SORT_CMP : ST_EMIT_RD;
        end
      end
      ST_STORE:    state_next = (need_flush) ? ST_STORE : ST_RESP;
      ST_RESP:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load_req = (state == ST_IDLE) && in_fire;
    unique case (state)
      ST_SCAN: begin
        cmd.scan_step = (mode_q != MODE_INSERT) && !sts.hit && !sts.scan_end;
        cmd.hit_latch = (mode_q != MODE_INSERT) && sts.hit;
        cmd.upd_write = (mode_q == MODE_UPDATE) && sts.hit;
        cmd.sort_init = 1'b1;
      end
      ST_SHIFT:    begin
        cmd.shift_step = !sts.shift_end;
        cmd.del_done   = sts.shift_end;
      end
      ST_SORT_CMP: cmd.sort_cmp = 1'b1;
      ST_EMIT_RD:  cmd.emit_rd  = 1'b1;
      ST_EMIT:     cmd.emit_step = out_free;
      ST_STORE:    cmd.store_pair = !need_flush;
      ST_RESP:     cmd.resp_load = out_free;
      default: ;
    endcase
  end
endmodule

FILE: design/lsm_dp.sv
// Storage, scan, delete shift, selection sort and output register of the memtable.
`timescale 1ns / 1ps
module lsm_dp import lsm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cmd_t           cmd,
  input  mode_t          mode_in,
  input  logic [63:0]    key_in,
  input  logic [63:0]    value_in,
  input  logic           out_ready,
  output mode_t          mode_q,
  output status_t        sts,
  output logic           out_valid,
  output logic           out_free,
  output logic [1:0]     kind,
  output logic           found,
  output logic [63:0]    out_key,
  output logic [63:0]    out_value,
  output logic           last,
  output logic [5:0]     fill_level
);
  logic [63:0] key_mem [BlockSize];
  logic [63:0] val_mem [BlockSize];
  logic [CntW-1:0] fill_count;
  logic [63:0] req_key, req_val;
  logic [IdxW-1:0] idx;          // scan / shift index
  logic [CntW-1:0] idx_ext;
  logic            hit;
  // sort: selection of smallest unemitted (stable: earliest among equals)
  logic [BlockSize-1:0] taken;
  logic [IdxW-1:0] sidx, best;
  logic            best_ok;
  logic [63:0]     best_key;
  logic [CntW-1:0] emit_n;
  logic            sorted;
  logic [63:0]     rd_key, rd_val;
  logic [IdxW-1:0] rd_addr;
  logic            resp_found, flushed;
  logic [63:0]     resp_val;

  assign idx_ext = {1'b0, idx};
  assign out_free = !out_valid || out_ready;
  assign sts.full      = (fill_count == CntW'(BlockSize));
  assign sts.hit       = hit;
  assign sts.scan_end  = (idx_ext + 1'b1 >= fill_count) && !hit;
  assign sts.shift_end = (idx_ext + 1'b1 >= fill_count);
  assign sts.sort_end  = (sidx == IdxW'(BlockSize - 1));
  assign sts.emit_end  = (emit_n == CntW'(BlockSize - 1));
  assign hit = (idx_ext < fill_count) && (key_mem[idx] == req_key);

  assign rd_addr = sorted ? best : IdxW'(emit_n);
  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
      taken      <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_req) begin
        mode_q     <= mode_in;
        req_key    <= key_in;
        req_val    <= value_in;
        idx        <= '0;
        resp_found <= 1'b0;
        flushed    <= 1'b0;
      end
      if (cmd.scan_step) idx <= idx + 1'b1;
      if (cmd.hit_latch) begin
        resp_found <= 1'b1;
        resp_val   <= val_mem[idx];
      end
      if (cmd.upd_write) val_mem[idx] <= req_val;
      if (cmd.shift_step) begin
        key_mem[idx] <= key_mem[idx + 1'b1];
        val_mem[idx] <= val_mem[idx + 1'b1];
        idx <= idx + 1'b1;
      end
      if (cmd.del_done) fill_count <= fill_count - 1'b1;
      if (cmd.sort_init) begin
        taken   <= '0;
        emit_n  <= '0;
        sidx    <= '0;
        best_ok <= 1'b0;
        sorted  <= 1'b0;
      end
      if (cmd.sort_cmp) begin
        if (!taken[sidx] && (!best_ok || key_mem[sidx] < best_key)) begin
          best <= sidx; best_key <= key_mem[sidx]; best_ok <= 1'b1;
        end
        sidx <= sidx + 1'b1;
        if (sts.sort_end) sorted <= 1'b1;
      end
      if (cmd.emit_step) begin
        out_valid  <= 1'b1;
        kind       <= KIND_RUN;
        found      <= 1'b0;
        out_key    <= rd_key;
        out_value  <= rd_val;
        last       <= sts.emit_end;
        fill_level <= 6'd1;
        emit_n     <= emit_n + 1'b1;
        flushed    <= 1'b1;
        if (sorted) begin
          taken[best] <= 1'b1;
          sorted  <= 1'b0;
          best_ok <= 1'b0;
          sidx    <= '0;
        end
        if (sts.emit_end) fill_count <= '0;
      end
      if (cmd.store_pair) begin
        key_mem[IdxW'(fill_count)] <= req_key;
        val_mem[IdxW'(fill_count)] <= req_val;
        fill_count <= fill_count + 1'b1;
      end
      // a flush already delivered this request's results
      if (cmd.resp_load && !flushed) begin
        out_valid  <= 1'b1;
        kind       <= (mode_q == MODE_LOOKUP) ? KIND_ANSWER : KIND_ACK;
        found      <= (mode_q == MODE_INSERT) ? 1'b0 : resp_found;
        out_key    <= (mode_q == MODE_LOOKUP && resp_found) ? req_key : '0;
        out_value  <= (mode_q == MODE_LOOKUP && resp_found) ? resp_val : '0;
        last       <= 1'b1;
        fill_level <= 6'(fill_count);
      end
    end
  end
endmodule

FILE: tb/tb_lsm_memtable_buffer.sv
// Testbench for the memtable write buffer: predicts each request's results and checks them.
`timescale 1ns / 1ps
module tb_lsm_memtable_buffer;
  import lsm_pkg::*;

  // one expected result of a request
  typedef struct {
    kind_t       kind;
    logic        found;
    logic [63:0] okey;
    logic [63:0] oval;
    logic        last;
    logic [5:0]  fill;
  } memtable_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_INSERT;
  logic [63:0] key = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        found;
  logic [63:0] out_key;
  logic [63:0] out_value;
  logic        last;
  logic [5:0]  fill_level;

  lsm_memtable_buffer uut (.*);

  always #6 clk = ~clk;

  // Predictor state: shadow copy of the buffer and the sort setting.
  logic [63:0] shadow_keys [BlockSize];
  logic [63:0] shadow_vals [BlockSize];
  int          shadow_fill;
  logic        shadow_sort;

  memtable_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  bit hold_off = 0;     // long receiver stall, driven by its own process
  bit rx_random = 1;

  // Small key space makes hits, duplicates and stable-sort ties common.
  logic [63:0] key_pool [8];

  // Flush of a full buffer: emits all entries, sorted stably if enabled.
  task automatic flush_run(ref memtable_result_t rs[$]);
    logic [63:0] ks [BlockSize];
    logic [63:0] vs [BlockSize];
    logic [63:0] ck, cv;
    int j;
    memtable_result_t r;
    for (int i = 0; i < BlockSize; i++) begin
      ks[i] = shadow_keys[i];
      vs[i] = shadow_vals[i];
    end
    if (shadow_sort) begin
      for (int i = 1; i < BlockSize; i++) begin
        ck = ks[i];
        cv = vs[i];
        j = i;
        while (j > 0 && ks[j-1] > ck) begin
          ks[j] = ks[j-1];
          vs[j] = vs[j-1];
          j--;
        end
        ks[j] = ck;
        vs[j] = cv;
      end
    end
    for (int i = 0; i < BlockSize; i++) begin
      r.kind = KIND_RUN;
      r.found = 0;
      r.okey = ks[i];
      r.oval = vs[i];
      r.last = (i == BlockSize - 1);
      rs.push_back(r);
    end
    shadow_fill = 0;
  endtask

  task automatic store_entry(logic [63:0] k, logic [63:0] v,
                             ref memtable_result_t rs[$]);
    if (shadow_fill >= BlockSize) flush_run(rs);
    shadow_keys[shadow_fill] = k;
    shadow_vals[shadow_fill] = v;
    shadow_fill++;
  endtask

  // Work out the results of one request and queue them.
  task automatic predict_request(mode_t m, logic [63:0] k, logic [63:0] v);
    memtable_result_t rs[$];
    memtable_result_t r;
    int hit;
    hit = -1;
    for (int i = 0; i < shadow_fill; i++)
      if (hit < 0 && shadow_keys[i] == k) hit = i;
    r.kind = KIND_ACK; r.found = 0; r.okey = '0; r.oval = '0; r.last = 1;
    case (m)
      MODE_INSERT: begin
        store_entry(k, v, rs);
      end
      MODE_LOOKUP: begin
        r.kind = KIND_ANSWER;
        if (hit >= 0) begin
          r.found = 1;
          r.okey = shadow_keys[hit];
          r.oval = shadow_vals[hit];
        end
      end
      MODE_DELETE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < shadow_fill; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_fill--;
          r.found = 1;
        end
      end
      default: begin
        if (hit >= 0) begin
          shadow_vals[hit] = v;
          r.found = 1;
        end else begin
          store_entry(k, v, rs);
        end
      end
    endcase
    if (rs.size() == 0) rs.push_back(r);
    foreach (rs[i]) begin
      rs[i].fill = shadow_fill[5:0];
      pending_results.push_back(rs[i]);
    end
  endtask

  // Send one request; predict once it is accepted. Valid stays up after the
  // accept until the next request or drain() takes it down.
  task automatic send_request(mode_t m, logic [63:0] k, logic [63:0] v,
                              bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(m, k, v);
  endtask

  // Write the sort setting; only called with nothing outstanding.
  task automatic write_sort(logic s);
    cfg_valid <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_sort = s;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    return ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)]
                                      : {$urandom, $urandom};
  endfunction

  // Receiver: random stall per result, or the long hold-off.
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (out_ready && out_valid) begin
        wait_n = rx_random ? $urandom_range(0, 7) : 0;
        if (wait_n != 0) begin
          out_ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    memtable_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d key=%h", $time, kind, out_key);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (kind != e.kind || found != e.found || out_key != e.okey ||
            out_value != e.oval || last != e.last || fill_level != e.fill) begin
          $display("%0t: mismatch exp kind=%0d found=%0b key=%h val=%h last=%0b fill=%0d",
                   $time, e.kind, e.found, e.okey, e.oval, e.last, e.fill);
          $display("%0t:          got kind=%0d found=%0b key=%h val=%h last=%0b fill=%0d",
                   $time, kind, found, out_key, out_value, last, fill_level);
          errors++;
        end
      end
    end
  end

  // Directed: field extremes, every mode, hits and misses, duplicate keys.
  task automatic test_directed();
    send_request(MODE_LOOKUP, 64'h0, 64'h0);                  // lookup miss, empty
    send_request(MODE_DELETE, '1, 64'h0);                     // delete miss
    send_request(MODE_INSERT, '1, '1);
    send_request(MODE_INSERT, 64'h0, 64'h0);
    send_request(MODE_INSERT, '1, 64'h5555_5555_5555_5555);   // duplicate key
    send_request(MODE_LOOKUP, '1, 64'h0);                     // oldest match wins
    send_request(MODE_UPDATE, '1, 64'hAAAA_AAAA_AAAA_AAAA);   // update hit
    send_request(MODE_UPDATE, 64'h1234, 64'h9);               // update miss inserts
    send_request(MODE_DELETE, '1, 64'h0);                     // delete hit, shift
    send_request(MODE_LOOKUP, '1, 64'h0);
    send_request(MODE_LOOKUP, 64'h1234, '1);
    send_request(MODE_DELETE, 64'h0, 64'h0);
    send_request(MODE_DELETE, 64'h1234, 64'h0);
    send_request(MODE_DELETE, '1, 64'h0);                     // back to empty
    drain();
  endtask

  // Fill the buffer and flush it, with a given sort setting.
  task automatic test_flush(logic s);
    write_sort(s);
    while (shadow_fill < BlockSize)
      send_request(MODE_INSERT, key_pool[$urandom_range(0, 7)],
                   {$urandom, $urandom});
    send_request($urandom_range(0, 1) ? MODE_INSERT : MODE_UPDATE,
                 {$urandom, $urandom}, {$urandom, $urandom});
    drain();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      repeat (12) send_request(mode_t'($urandom_range(0, 3)), pick_key(),
                               {$urandom, $urandom}, 1);
    join
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    mode_t m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      m = (r < 5) ? MODE_INSERT : (r < 7) ? MODE_LOOKUP :
          (r < 8) ? MODE_DELETE : MODE_UPDATE;
      rx_random = (i % 60) < 45;
      send_request(m, pick_key(), {$urandom, $urandom}, (i % 60) >= 45);
      if (i == n / 2) begin
        drain();
        write_sort(~shadow_sort);
      end
    end
    rx_random = 1;
    drain();
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    shadow_fill = 0;
    shadow_sort = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_flush(1'b1);
    test_flush(1'b0);
    test_backpressure();
    test_random(220);
    if (errors == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog: sorted flushes dominate the run time.
  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
